[rtl/core/contour_line_angle_assert.svh]
// ----------------------------------------------------------------------------
// contour_line_angle assertion macros
// Concurrent checks on clk with rst as the disable condition. Define
// NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef CONTOUR_LINE_ANGLE_ASSERT_SVH
`define CONTOUR_LINE_ANGLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CLA_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("contour_line_angle: same-cycle check failed");
// next-cycle implication
`define CLA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("contour_line_angle: next-cycle check failed");
`else
`define CLA_ASSERT_IMPL(name, ante, cons)
`define CLA_ASSERT_NEXT(name, ante, cons)
`endif
`endif

[rtl/core/cla_pkg.sv]
// ----------------------------------------------------------------------------
// cla_pkg
// Shared types, constants and the arctangent table of the line angle block.
// ----------------------------------------------------------------------------
package cla_pkg;

  localparam int DEF_MAX_POINTS      = 65536;
  localparam int DEF_COORD_BITS      = 11;
  localparam int DEF_ANGLE_FRAC_BITS = 13;

  localparam int ANGLE_W      = 16;
  localparam int CENTER_RESET = 480;

  // CORDIC: table in Q24, inputs normalized below 2^NORM_BITS
  localparam int TAB_BITS     = 24;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);
  localparam int TAB_W        = TAB_BITS + 1;
  localparam int NORM_BITS    = 30;
  localparam int CX_W         = NORM_BITS + 4;
  localparam int Z_W          = TAB_BITS + 3;
  localparam longint PI_Q24   = 52707179;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_PREP,
    ST_MUL_NXY,
    ST_MUL_SXSY,
    ST_MUL_NYY,
    ST_MUL_SYSY,
    ST_NORM,
    ST_CORDIC,
    ST_OUT
  } cla_state_t;

  // atan(2^-i) in Q24, rounded to nearest
  function automatic logic [TAB_W-1:0] cla_atan(input logic [STEP_W-1:0] idx);
    logic [TAB_W-1:0] v;
    case (idx)
      5'd0:    v = 25'd13176795;
      5'd1:    v = 25'd7778716;
      5'd2:    v = 25'd4110060;
      5'd3:    v = 25'd2086331;
      5'd4:    v = 25'd1047214;
      5'd5:    v = 25'd524117;
      5'd6:    v = 25'd262123;
      5'd7:    v = 25'd131069;
      5'd8:    v = 25'd65536;
      5'd9:    v = 25'd32768;
      5'd10:   v = 25'd16384;
      5'd11:   v = 25'd8192;
      5'd12:   v = 25'd4096;
      5'd13:   v = 25'd2048;
      5'd14:   v = 25'd1024;
      5'd15:   v = 25'd512;
      5'd16:   v = 25'd256;
      5'd17:   v = 25'd128;
      5'd18:   v = 25'd64;
      5'd19:   v = 25'd32;
      5'd20:   v = 25'd16;
      5'd21:   v = 25'd8;
      5'd22:   v = 25'd4;
      5'd23:   v = 25'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/cla_mul.sv]
// ----------------------------------------------------------------------------
// cla_mul
// Shift-add multiplier, one multiplier bit per cycle, product kept modulo
// 2^P_W. Finishes early once the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module cla_mul #(
  parameter int A_W = 39,
  parameter int B_W = 28,
  parameter int P_W = 56
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  output logic           done,
  output logic [P_W-1:0] product
);

  logic [P_W-1:0] acc;
  logic [P_W-1:0] a_sh;
  logic [B_W-1:0] b_sh;
  logic           running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && b_sh == '0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_sh <= P_W'(a);
      b_sh <= b;
    end else if (running && b_sh != '0) begin
      if (b_sh[0]) begin
        acc <= acc + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

  assign product = acc;

endmodule

[rtl/core/cla_cordic.sv]
// ----------------------------------------------------------------------------
// cla_cordic
// Vectoring CORDIC, one rotation per cycle: angle of (x, y) in Q24, clamped
// at zero.
// ----------------------------------------------------------------------------
module cla_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cla_pkg::NORM_BITS-1:0] x_in,
  input  logic [cla_pkg::NORM_BITS-1:0] y_in,
  output logic                          done,
  output logic [cla_pkg::Z_W-2:0]       z_out
);
  import cla_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

  logic signed [CX_W-1:0] x, y, dx, dy;
  logic signed [Z_W-1:0]  z, tab;
  logic [STEP_W-1:0]      step;
  logic                   busy;

  always_comb begin
    dx  = x >>> step;
    dy  = y >>> step;
    tab = $signed(Z_W'(cla_atan(step)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= $signed(CX_W'(x_in));
      y    <= $signed(CX_W'(y_in));
      z    <= '0;
      step <= '0;
    end else if (busy) begin
      // rotate toward the x axis
      if (!y[CX_W-1]) begin
        x <= x + dy;
        y <= y - dx;
        z <= z + tab;
      end else begin
        x <= x - dy;
        y <= y + dx;
        z <= z - tab;
      end
      step <= step + 1'b1;
    end
  end

  assign z_out = z[Z_W-1] ? '0 : z[Z_W-2:0];

endmodule

[rtl/core/contour_line_angle.sv]
// ----------------------------------------------------------------------------
// contour_line_angle
// Least-squares line fit over the points of one region, angle out as Q3.13.
// ----------------------------------------------------------------------------
// For a point beat that is not the last, busy is high only in ST_ACC, the cycle after start.
// After the last point, the one shift-add multiplier forms four products in turn,
// normalization halves both operands while either is at least 2^NORM_BITS, and the
// CORDIC runs unless there is no angle; angle_valid is a registered strobe from ST_OUT.
// The receiver cannot stall; the strobe lasts one cycle.
// Synchronous rst clears the sums and count and sets center_row to 480.
`include "contour_line_angle_assert.svh"

module contour_line_angle #(
  parameter int MAX_POINTS      = cla_pkg::DEF_MAX_POINTS,
  parameter int COORD_BITS      = cla_pkg::DEF_COORD_BITS,
  parameter int ANGLE_FRAC_BITS = cla_pkg::DEF_ANGLE_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [COORD_BITS-1:0]               point_x,
  input  logic [COORD_BITS-1:0]               point_y,
  input  logic                                last_point,
  input  logic                                cfg_we,
  input  logic [COORD_BITS:0]                 cfg_wdata,
  output logic signed [cla_pkg::ANGLE_W-1:0]  angle,
  output logic                                angle_valid
);
  import cla_pkg::*;

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = COORD_BITS + CNT_W;
  localparam int PRD_W  = 2 * COORD_BITS;
  localparam int SQ_W   = PRD_W + CNT_W;
  localparam int FULL_W = SQ_W + CNT_W;
  localparam int P_W    = (FULL_W > 64) ? 64 : FULL_W;
  localparam int DIST_W = COORD_BITS + 1;
  localparam int RND_SH = TAB_BITS - ANGLE_FRAC_BITS;
  localparam int A_W    = Z_W + 1;
  localparam int F_W    = Z_W + 2;
  localparam longint PI_OUT = (PI_Q24 + (longint'(1) << (RND_SH - 1))) >> RND_SH;
  localparam logic signed [F_W-1:0] PI_Q = F_W'(PI_OUT);
  localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_POINTS);
  localparam logic [DIST_W-1:0] CTR_RST = DIST_W'(CENTER_RESET);

  cla_state_t state, state_next;

  logic [DIST_W-1:0]     center_row;
  logic [CNT_W-1:0]      point_count;
  logic [SUM_W-1:0]      sum_col, sum_row;
  logic [SQ_W-1:0]       sum_col_row, sum_row_sq;
  logic [COORD_BITS-1:0] far_row, near_row;
  logic [COORD_BITS-1:0] pt_x, pt_y;
  logic                  pt_last;
  logic [PRD_W-1:0]      pt_xy, pt_yy;
  logic [DIST_W-1:0]     pt_dist, pt_trunc, far_dist, near_dist;

  logic                  mul_start, mul_done;
  logic [SQ_W-1:0]       mul_a;
  logic [SUM_W-1:0]      mul_b;
  logic [P_W-1:0]        mul_p;

  logic [P_W-1:0]        p_hold, mag, den, den_calc;
  logic                  neg, has_angle, pos, norm_big;

  logic                  cordic_start, cordic_done;
  logic [Z_W-2:0]        cordic_z;
  logic [Z_W-1:0]        z_sum;
  logic signed [A_W-1:0] a_rnd, a_q;
  logic signed [F_W-1:0] angle_full;

  function automatic logic [DIST_W-1:0] half_dist(input logic [COORD_BITS-1:0] row,
                                                  input logic [DIST_W-1:0] ctr);
    logic [DIST_W-1:0] twice;
    twice = {row, 1'b0};
    return (twice >= ctr) ? twice - ctr : ctr - twice;
  endfunction

  // --------------------------------------------------------------------------
  // Shared units
  // --------------------------------------------------------------------------
  cla_mul #(
    .A_W (SQ_W),
    .B_W (SUM_W),
    .P_W (P_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  cla_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .x_in  (NORM_BITS'(den)),
    .y_in  (NORM_BITS'(mag)),
    .done  (cordic_done),
    .z_out (cordic_z)
  );

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  always_comb begin
    pt_dist   = half_dist(pt_y, center_row);
    pt_trunc  = {pt_dist[DIST_W-1:1], 1'b0};
    far_dist  = half_dist(far_row, center_row);
    near_dist = half_dist(near_row, center_row);
    den_calc  = (p_hold >= mul_p) ? p_hold - mul_p : '0;
    norm_big  = |((mag | den) >> NORM_BITS);
    pos       = has_angle && !neg;
    z_sum     = {1'b0, cordic_z} + (Z_W'(1) << (RND_SH - 1));
    a_rnd     = $signed({1'b0, z_sum >> RND_SH});
    if (far_row == near_row) begin
      angle_full = '0;
    end else if (far_row > near_row) begin
      angle_full = F_W'(a_q);
    end else if (pos) begin
      angle_full = F_W'(a_q) - PI_Q;
    end else begin
      angle_full = F_W'(a_q) + PI_Q;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (start) state_next = ST_ACC;
      ST_ACC:      state_next = pt_last ? ST_PREP : ST_IDLE;
      ST_PREP:     state_next = ST_MUL_NXY;
      ST_MUL_NXY:  if (mul_done) state_next = ST_MUL_SXSY;
      ST_MUL_SXSY: if (mul_done) state_next = ST_MUL_NYY;
      ST_MUL_NYY:  if (mul_done) state_next = ST_MUL_SYSY;
      ST_MUL_SYSY: if (mul_done) state_next = ST_NORM;
      ST_NORM: begin
        if (!has_angle) begin
          state_next = ST_OUT;
        end else if (!norm_big) begin
          state_next = ST_CORDIC;
        end
      end
      ST_CORDIC:   if (cordic_done) state_next = ST_OUT;
      ST_OUT:      state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state != ST_IDLE);
    mul_start    = (state_next != state) &&
                   (state_next inside {ST_MUL_NXY, ST_MUL_SXSY, ST_MUL_NYY, ST_MUL_SYSY});
    cordic_start = (state == ST_NORM) && (state_next == ST_CORDIC);
    case (state_next)
      ST_MUL_NXY: begin
        mul_a = sum_col_row;
        mul_b = SUM_W'(point_count);
      end
      ST_MUL_SXSY: begin
        mul_a = SQ_W'(sum_col);
        mul_b = sum_row;
      end
      ST_MUL_NYY: begin
        mul_a = sum_row_sq;
        mul_b = SUM_W'(point_count);
      end
      ST_MUL_SYSY: begin
        mul_a = SQ_W'(sum_row);
        mul_b = sum_row;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers and sums
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      center_row  <= CTR_RST;
      point_count <= '0;
      sum_col     <= '0;
      sum_row     <= '0;
      sum_col_row <= '0;
      sum_row_sq  <= '0;
      angle_valid <= 1'b0;
    end else begin
      state       <= state_next;
      angle_valid <= 1'b0;
      if (cfg_we) begin
        center_row <= cfg_wdata;
      end
      if (state == ST_ACC && point_count < CNT_MAX) begin
        point_count <= point_count + 1'b1;
        sum_col     <= sum_col + SUM_W'(pt_x);
        sum_row     <= sum_row + SUM_W'(pt_y);
        sum_col_row <= sum_col_row + SQ_W'(pt_xy);
        sum_row_sq  <= sum_row_sq + SQ_W'(pt_yy);
      end
      if (state == ST_OUT) begin
        angle_valid <= 1'b1;
        point_count <= '0;
        sum_col     <= '0;
        sum_row     <= '0;
        sum_col_row <= '0;
        sum_row_sq  <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      pt_x    <= point_x;
      pt_y    <= point_y;
      pt_last <= last_point;
      pt_xy   <= PRD_W'(point_x) * PRD_W'(point_y);
      pt_yy   <= PRD_W'(point_y) * PRD_W'(point_y);
    end

    // drop points past capacity; the first point seeds both rows
    if (state == ST_ACC && point_count < CNT_MAX) begin
      if (point_count == '0) begin
        far_row  <= pt_y;
        near_row <= pt_y;
      end else begin
        if (pt_trunc > far_dist) begin
          far_row <= pt_y;
        end
        if (pt_trunc < near_dist) begin
          near_row <= pt_y;
        end
      end
    end

    case (state)
      ST_MUL_NXY: if (mul_done) p_hold <= mul_p;
      ST_MUL_SXSY: begin
        if (mul_done) begin
          neg <= (p_hold < mul_p);
          mag <= (p_hold >= mul_p) ? p_hold - mul_p : mul_p - p_hold;
        end
      end
      ST_MUL_NYY: if (mul_done) p_hold <= mul_p;
      ST_MUL_SYSY: begin
        if (mul_done) begin
          den       <= den_calc;
          has_angle <= (den_calc != '0) && (mag != '0);
        end
      end
      ST_NORM: begin
        if (!has_angle) begin
          a_q <= '0;
        end else if (norm_big) begin
          mag <= mag >> 1;
          den <= den >> 1;
        end
      end
      ST_CORDIC: if (cordic_done) a_q <= neg ? -a_rnd : a_rnd;
      ST_OUT: angle <= angle_full[ANGLE_W-1:0];
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CLA_ASSERT_NEXT(a_valid_one_cycle, angle_valid, !angle_valid)
  `CLA_ASSERT_IMPL(a_valid_after_out, angle_valid, $past(state == ST_OUT))
  `CLA_ASSERT_NEXT(a_beat_to_acc, start && !busy, state == ST_ACC)
  `CLA_ASSERT_IMPL(a_count_bound, 1'b1, point_count <= CNT_MAX)

endmodule
